>>> hw/rtl/cse_pkg.sv
// shared types and constants for the cubic spline evaluator
`timescale 1ns / 1ps
package cse_pkg;
  localparam int MAX_KNOTS = 256;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  typedef struct packed {
    logic        is_eval;
    logic [7:0]  index;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] u;
  } cmd_t;
endpackage

>>> hw/rtl/cubic_spline_evaluator.sv
// top level of the cubic spline evaluator
`timescale 1ns / 1ps
// Items enter a two-deep queue, then are handled one at a time. A write
// item is stored straight from the idle state. An evaluate item first
// checks the cached segment and, on a miss, runs a binary search with
// one memory read per search step; it then runs three shared multiply-add
// passes. A result waits in an output register; the
// back end holds in its last state only when a second result is ready
// before the first is taken. Table entries are undefined until written.
module cubic_spline_evaluator #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  entry_index,
  input  logic [31:0] knot_x,
  input  logic [31:0] value_y,
  input  logic [31:0] coef_b,
  input  logic [31:0] coef_c,
  input  logic [31:0] coef_d,
  input  logic [31:0] point_u,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] spline_value,
  output logic [7:0]  segment_used
);
  logic [8:0]    knot_count;
  cse_pkg::cmd_t in_cmd;
  cse_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_ready;

  always_ff @(posedge clk) begin
    if (rst) knot_count <= 9'd2;
    else if (cfg_we) knot_count <= cfg_wdata;
  end

  assign in_cmd = '{is_eval: (req_type == cse_pkg::REQ_EVAL), index: entry_index,
                    x: knot_x, y: value_y, b: coef_b, c: coef_c, d: coef_d,
                    u: point_u};

  cse_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  cse_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .knot_count(knot_count), .q_valid(q_valid),
    .q_ready(q_ready), .q_cmd(q_cmd), .out_valid(out_valid),
    .out_ready(out_ready), .spline_value(spline_value),
    .segment_used(segment_used)
  );
endmodule

>>> hw/rtl/cse_front.sv
// front end: accepts items into a small command queue
`timescale 1ns / 1ps
module cse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cse_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output cse_pkg::cmd_t q_cmd
);
  cse_pkg::cmd_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("pop while empty");
endmodule

>>> hw/rtl/cse_back.sv
// back end: table memories, segment search and horner evaluation
`timescale 1ns / 1ps
module cse_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [8:0]    knot_count,
  input  logic          q_valid,
  output logic          q_ready,
  input  cse_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   spline_value,
  output logic [7:0]    segment_used
);
  localparam int AW = (cse_pkg::MAX_KNOTS > 2) ? $clog2(cse_pkg::MAX_KNOTS) : 1;
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;
  localparam logic [3:0] S_CLO   = 4'd2;
  localparam logic [3:0] S_CHI   = 4'd3;
  localparam logic [3:0] S_BRD   = 4'd4;
  localparam logic [3:0] S_BCMP  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FLD   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [31:0] mem_x [cse_pkg::MAX_KNOTS];
  logic [31:0] mem_y [cse_pkg::MAX_KNOTS];
  logic [31:0] mem_b [cse_pkg::MAX_KNOTS];
  logic [31:0] mem_c [cse_pkg::MAX_KNOTS];
  logic [31:0] mem_d [cse_pkg::MAX_KNOTS];

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_x, rd_y, rd_b, rd_c, rd_d;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] lo, hi, mid;
  logic [AW-1:0] last_segment;
  logic [AW-1:0] seg;
  logic [31:0] u;
  logic        lo_ok;
  logic signed [32:0] dx;
  logic signed [31:0] acc;
  logic signed [31:0] coef_y, coef_b, coef_c;
  logic [1:0]  stage;
  logic signed [64:0] prod;
  logic signed [64:0] prod_q;
  logic signed [65:0] sum;
  logic signed [31:0] sat;
  logic [31:0] res;
  logic [AW-1:0] res_seg;
  logic        res_valid;
  logic        out_free;

  always_comb begin
    if (knot_count < 9'd2) n_eff = CW'(2);
    else if (32'(knot_count) > 32'(cse_pkg::MAX_KNOTS)) n_eff = CW'(cse_pkg::MAX_KNOTS);
    else n_eff = CW'(knot_count);
  end

  assign mid = CW'((CW+1)'(lo) + (CW+1)'(hi) >> 1);
  assign q_ready = (state == S_IDLE);
  assign out_free = !res_valid || out_ready;

  always_comb begin
    unique case (state)
      S_CRD:   rd_addr = last_segment;
      S_CLO:   rd_addr = last_segment + AW'(1);
      S_BRD:   rd_addr = mid[AW-1:0];
      default: rd_addr = seg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && !q_cmd.is_eval &&
        32'(q_cmd.index) < 32'(cse_pkg::MAX_KNOTS)) begin
      mem_x[AW'(q_cmd.index)] <= q_cmd.x;
      mem_y[AW'(q_cmd.index)] <= q_cmd.y;
      mem_b[AW'(q_cmd.index)] <= q_cmd.b;
      mem_c[AW'(q_cmd.index)] <= q_cmd.c;
      mem_d[AW'(q_cmd.index)] <= q_cmd.d;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_b <= mem_b[rd_addr];
    rd_c <= mem_c[rd_addr];
    rd_d <= mem_d[rd_addr];
  end

  assign prod = dx * $signed(state == S_MUL && stage == 2'd0 ? rd_d : acc);
  assign sum  = 66'(prod_q >>> FRAC_BITS) + 66'(stage == 2'd0 ? coef_c :
                stage == 2'd1 ? coef_b : coef_y);
  always_comb begin
    if (sum > 66'sh7fffffff) sat = 32'sh7fffffff;
    else if (sum < -66'sh80000000) sat = 32'sh80000000;
    else sat = sum[31:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid && q_cmd.is_eval) state_next = S_CRD;
      S_CRD:   state_next = S_CLO;
      S_CLO:   state_next = S_CHI;
      S_CHI:   state_next = (lo_ok && $signed(u) < $signed(rd_x)) ? S_FRD : S_BRD;
      S_BRD:   state_next = S_BCMP;
      S_BCMP:  state_next = S_BRD;
      S_FRD:   state_next = S_FLD;
      S_FLD:   state_next = S_MUL;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = (stage == 2'd2) ? S_OUT : S_MUL;
      S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
    if (state == S_BRD && hi <= lo + CW'(1)) state_next = S_FRD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last_segment <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          u <= q_cmd.u;
          if (32'(last_segment) >= 32'(n_eff) - 1) last_segment <= '0;
        end
        S_CLO: lo_ok <= $signed(u) >= $signed(rd_x);
        S_CHI: begin
          seg <= last_segment;
          lo  <= '0;
          hi  <= n_eff;
        end
        S_BCMP: begin
          if ($signed(u) < $signed(rd_x)) hi <= mid;
          else lo <= mid;
        end
        S_FLD: begin
          dx <= 33'($signed(u)) - 33'($signed(rd_x));
          coef_y <= rd_y;
          coef_b <= rd_b;
          coef_c <= rd_c;
          stage  <= 2'd0;
        end
        S_MUL: prod_q <= prod;
        S_ADD: begin
          acc <= sat;
          stage <= stage + 2'd1;
        end
        S_OUT: begin
          if (out_free) begin
            res <= acc;
            res_seg <= seg;
          end
        end
        default: ;
      endcase
      if (state == S_BRD && hi <= lo + CW'(1)) begin
        seg <= lo[AW-1:0];
        last_segment <= lo[AW-1:0];
      end
      if (state == S_OUT && out_free) res_valid <= 1'b1;
      else if (out_valid && out_ready) res_valid <= 1'b0;
    end
  end

  assign out_valid    = res_valid;
  assign spline_value = res;
  assign segment_used = 8'(res_seg);

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == S_IDLE) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_ready |=> res_valid) else $error("result dropped");
  a_search_order: assert property (@(posedge clk) disable iff (rst)
    state == S_BCMP |-> lo < hi) else $error("search bounds crossed");
endmodule
